[sv/tic_pkg.sv]
// tic_pkg: shared types and codes for the transmit interrupt coalescer.
// Used by tic_front, tic_queue, tic_back and the top level; depends on nothing.
package tic_pkg;

    localparam int OP_W     = 3;
    localparam int NIC_IN_W = 2;
    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 13;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 5;
    localparam int INF_OUT_W = 6;
    localparam int STAT_W   = 32;
    localparam int SINCE_W  = 16;
    localparam int LOG2_W   = 3;
    localparam int MARGIN_W = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // operation codes on the request port
    localparam logic [OP_W-1:0] OPC_POST    = 3'd0;
    localparam logic [OP_W-1:0] OPC_PIO     = 3'd1;
    localparam logic [OP_W-1:0] OPC_RECLAIM = 3'd2;
    localparam logic [OP_W-1:0] OPC_READ    = 3'd3;
    localparam logic [OP_W-1:0] OPC_CLEAR   = 3'd4;
    localparam logic [OP_W-1:0] OPC_INIT    = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_EVERY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN    = 1'b1;

    // classified operation
    typedef enum logic [2:0] {
        OP_POST,
        OP_PIO,
        OP_RECLAIM,
        OP_READ,
        OP_CLEAR,
        OP_INIT
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic                nic_ok;
        logic [NIC_IN_W-1:0] nic;
        logic [ADDR_W-1:0]   buffer_addr;
        logic [LEN_W-1:0]    frame_length;
        logic                tail_complete;
    } item_t;

endpackage

[sv/tx_interrupt_coalescer_top.sv]
// tx_interrupt_coalescer_top: top level of the transmit interrupt coalescer.
// Depends on tic_pkg, tic_front, tic_queue and tic_back (which holds tic_ram).
//
// Usage:
//  - Requests: drive operation, nic, buffer_addr, frame_length and tail_complete
//    with start high; the request is taken at a clock edge where busy is low.
//    busy rises only when the two-entry request queue is full.
//  - Results: exactly one per request, in request order, shown for one cycle
//    with result_valid high. The receiver cannot stall; results are never held.
//  - Path: a request passes through the queue, then the back-end register, on
//    its way to the result ports; a reclaim that retires a descriptor also
//    waits for the read of the buffer address store.
//  - Throughput: one request per cycle, but each retiring reclaim holds the
//    back end in a wait state, set by the registered read port of the store.
//  - Configuration: cfg_we, cfg_index, cfg_data write irq_every_log2 (index 0)
//    or near_full_margin (index 1), one per write; write only while idle.
//  - Reset: rst_n clears all ring indices, counters and the queue; the
//    registers return to 3 and 2. The buffer store is not cleared: reclaiming
//    a slot whose address was never written gives an undefined address.
//  - Per-controller state lives in flip-flops; buffer addresses live in a
//    NIC_COUNT x RING_SIZE RAM.
module tx_interrupt_coalescer_top #(
    parameter int NIC_COUNT = 4,
    parameter int RING_SIZE = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // request channel
    input  logic                                 start,
    output logic                                 busy,
    input  logic [tic_pkg::OP_W-1:0]             operation,
    input  logic [tic_pkg::NIC_IN_W-1:0]         nic,
    input  logic [tic_pkg::ADDR_W-1:0]           buffer_addr,
    input  logic [tic_pkg::LEN_W-1:0]            frame_length,
    input  logic                                 tail_complete,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [tic_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tic_pkg::CFG_DATA_W-1:0]       cfg_data,
    // result channel
    output logic                                 result_valid,
    output logic [tic_pkg::STATUS_W-1:0]         status,
    output logic [tic_pkg::SLOT_W-1:0]           slot,
    output logic                                 irq_request,
    output logic [tic_pkg::LEN_W-1:0]            length_out,
    output logic [tic_pkg::ADDR_W-1:0]           freed_addr,
    output logic                                 free_needed,
    output logic [tic_pkg::INF_OUT_W-1:0]        inflight_out,
    output logic [tic_pkg::STAT_W-1:0]           packets_total,
    output logic [tic_pkg::STAT_W-1:0]           interrupts_total,
    output logic [tic_pkg::STAT_W-1:0]           empty_irqs,
    output logic [tic_pkg::STAT_W-1:0]           periodic_irqs
);

    logic [tic_pkg::LOG2_W-1:0]   irq_every_log2_reg;
    logic [tic_pkg::MARGIN_W-1:0] near_full_margin_reg;

    logic           push, q_full, q_valid, q_pop;
    tic_pkg::item_t front_item, q_item;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irq_every_log2_reg   <= 3'd3;
            near_full_margin_reg <= 4'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tic_pkg::CFG_IRQ_EVERY: irq_every_log2_reg   <= cfg_data[tic_pkg::LOG2_W-1:0];
                tic_pkg::CFG_MARGIN:    near_full_margin_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign busy = q_full;

    tic_front #(
        .NIC_COUNT (NIC_COUNT)
    ) u_front (
        .start         (start),
        .queue_full    (q_full),
        .operation     (operation),
        .nic           (nic),
        .buffer_addr   (buffer_addr),
        .frame_length  (frame_length),
        .tail_complete (tail_complete),
        .push          (push),
        .item          (front_item)
    );

    tic_queue #(
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (q_pop),
        .valid     (q_valid),
        .full      (q_full),
        .head_item (q_item)
    );

    tic_back #(
        .NIC_COUNT (NIC_COUNT),
        .RING_SIZE (RING_SIZE)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop),
        .irq_every_log2   (irq_every_log2_reg),
        .near_full_margin (near_full_margin_reg),
        .result_valid     (result_valid),
        .status           (status),
        .slot             (slot),
        .irq_request      (irq_request),
        .length_out       (length_out),
        .freed_addr       (freed_addr),
        .free_needed      (free_needed),
        .inflight_out     (inflight_out),
        .packets_total    (packets_total),
        .interrupts_total (interrupts_total),
        .empty_irqs       (empty_irqs),
        .periodic_irqs    (periodic_irqs)
    );

endmodule

[sv/tic_ram.sv]
// tic_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/tic_front.sv]
// tic_front: request acceptance and operation classification.
// Depends on tic_pkg.
module tic_front #(
    parameter int NIC_COUNT = 4
) (
    input  logic                              start,
    input  logic                              queue_full,
    input  logic [tic_pkg::OP_W-1:0]          operation,
    input  logic [tic_pkg::NIC_IN_W-1:0]      nic,
    input  logic [tic_pkg::ADDR_W-1:0]        buffer_addr,
    input  logic [tic_pkg::LEN_W-1:0]         frame_length,
    input  logic                              tail_complete,
    output logic                              push,
    output tic_pkg::item_t                    item
);

    tic_pkg::op_t op_dec;

    always_comb
    begin
        unique case (operation) inside
            tic_pkg::OPC_POST:    op_dec = tic_pkg::OP_POST;
            tic_pkg::OPC_PIO:     op_dec = tic_pkg::OP_PIO;
            tic_pkg::OPC_RECLAIM: op_dec = tic_pkg::OP_RECLAIM;
            tic_pkg::OPC_CLEAR:   op_dec = tic_pkg::OP_CLEAR;
            tic_pkg::OPC_INIT:    op_dec = tic_pkg::OP_INIT;
            default:              op_dec = tic_pkg::OP_READ; // read and unused codes
        endcase
    end

    assign push               = start && !queue_full;
    assign item.op            = op_dec;
    assign item.nic_ok        = (32'(nic) < NIC_COUNT);
    assign item.nic           = nic;
    assign item.buffer_addr   = buffer_addr;
    assign item.frame_length  = frame_length;
    assign item.tail_complete = tail_complete;

endmodule

[sv/tic_queue.sv]
// tic_queue: short request queue between front and back.
// Depends on tic_pkg.
module tic_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tic_pkg::item_t push_item,
    input  logic           pop,
    output logic           valid,
    output logic           full,
    output tic_pkg::item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tic_pkg::item_t    slots_reg [DEPTH];
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign valid     = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign head_item = slots_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && valid;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[sv/tic_back.sv]
// tic_back: per-controller ring state, interrupt decision and result register.
// Depends on tic_pkg and tic_ram (buffer address store).
module tic_back #(
    parameter int NIC_COUNT = 4,
    parameter int RING_SIZE = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  tic_pkg::item_t                      q_item,
    output logic                                q_pop,
    input  logic [tic_pkg::LOG2_W-1:0]          irq_every_log2,
    input  logic [tic_pkg::MARGIN_W-1:0]        near_full_margin,
    output logic                                result_valid,
    output logic [tic_pkg::STATUS_W-1:0]        status,
    output logic [tic_pkg::SLOT_W-1:0]          slot,
    output logic                                irq_request,
    output logic [tic_pkg::LEN_W-1:0]           length_out,
    output logic [tic_pkg::ADDR_W-1:0]          freed_addr,
    output logic                                free_needed,
    output logic [tic_pkg::INF_OUT_W-1:0]       inflight_out,
    output logic [tic_pkg::STAT_W-1:0]          packets_total,
    output logic [tic_pkg::STAT_W-1:0]          interrupts_total,
    output logic [tic_pkg::STAT_W-1:0]          empty_irqs,
    output logic [tic_pkg::STAT_W-1:0]          periodic_irqs
);

    localparam int NIC_W   = (NIC_COUNT > 1) ? $clog2(NIC_COUNT) : 1;
    localparam int IDX_W   = $clog2(RING_SIZE);
    localparam int INF_W   = $clog2(RING_SIZE + 1);
    localparam int SUM_W   = INF_W + tic_pkg::MARGIN_W + 1;
    localparam int DEPTH   = NIC_COUNT * RING_SIZE;
    localparam int RADDR_W = $clog2(DEPTH);
    localparam int SW      = tic_pkg::STAT_W;

    typedef enum logic {S_IDLE, S_WAIT} state_t;

    state_t state_reg;
    tic_pkg::item_t held_reg;

    logic [tic_pkg::SINCE_W-1:0] since_reg   [NIC_COUNT];
    logic [INF_W-1:0]            inf_reg     [NIC_COUNT];
    logic [IDX_W-1:0]            head_reg    [NIC_COUNT];
    logic [IDX_W-1:0]            tail_reg    [NIC_COUNT];
    logic [SW-1:0]               pkt_reg     [NIC_COUNT];
    logic [SW-1:0]               irq_reg     [NIC_COUNT];
    logic [SW-1:0]               empty_reg   [NIC_COUNT];
    logic [SW-1:0]               period_reg  [NIC_COUNT];

    tic_pkg::item_t cur;
    logic [NIC_W-1:0] nic_idx;
    logic go, to_wait, emit, upd;

    logic [tic_pkg::SINCE_W-1:0] since_next, since_inc, mask;
    logic [INF_W-1:0]            inf_next, inf_c;
    logic [IDX_W-1:0]            head_next, tail_next, head_c, tail_c;
    logic [SW-1:0]               pkt_next, irq_next, empty_next, period_next;
    logic [SUM_W-1:0]            fill_sum;

    logic [tic_pkg::STATUS_W-1:0] status_next;
    logic [IDX_W-1:0]             slot_next;
    logic                         irq_bit, need_next;
    logic [tic_pkg::LEN_W-1:0]    len_next;
    logic [tic_pkg::ADDR_W-1:0]   freed_next;

    logic                       ram_we, ram_re;
    logic [RADDR_W-1:0]         ram_waddr, ram_raddr;
    logic [tic_pkg::ADDR_W-1:0] ram_wdata, ram_rdata;

    tic_ram #(
        .WIDTH (tic_pkg::ADDR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cur     = (state_reg == S_IDLE) ? q_item : held_reg;
    assign go      = ((state_reg == S_IDLE) && q_valid) || (state_reg == S_WAIT);
    assign q_pop   = (state_reg == S_IDLE) && q_valid;
    assign nic_idx = NIC_W'(cur.nic);

    assign inf_c     = inf_reg[nic_idx];
    assign head_c    = head_reg[nic_idx];
    assign tail_c    = tail_reg[nic_idx];
    assign since_inc = since_reg[nic_idx] + 1'b1;
    assign mask      = (tic_pkg::SINCE_W'(1) << irq_every_log2) - 1'b1;
    assign fill_sum  = SUM_W'(inf_c) + SUM_W'(near_full_margin);

    assign ram_waddr = RADDR_W'(int'(nic_idx) * RING_SIZE
                                + int'((cur.op == tic_pkg::OP_POST) ? head_c : tail_c));
    assign ram_raddr = ram_waddr;

    always_comb
    begin
        since_next  = since_reg[nic_idx];
        inf_next    = inf_c;
        head_next   = head_c;
        tail_next   = tail_c;
        pkt_next    = pkt_reg[nic_idx];
        irq_next    = irq_reg[nic_idx];
        empty_next  = empty_reg[nic_idx];
        period_next = period_reg[nic_idx];
        status_next = tic_pkg::ST_OK;
        slot_next   = '0;
        irq_bit     = 1'b0;
        len_next    = '0;
        freed_next  = '0;
        need_next   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_wdata   = '0;
        to_wait     = 1'b0;

        if (go && cur.nic_ok)
        begin
            case (cur.op) inside
                tic_pkg::OP_POST, tic_pkg::OP_PIO:
                begin
                    if (inf_c >= INF_W'(RING_SIZE))
                    begin
                        status_next = tic_pkg::ST_FULL;
                        slot_next   = head_c;
                    end
                    else if (cur.op == tic_pkg::OP_POST)
                    begin
                        slot_next = head_c;
                        len_next  = cur.frame_length;
                        ram_we    = 1'b1;
                        ram_wdata = cur.buffer_addr;
                        if (inf_c == '0)
                        begin
                            irq_bit    = 1'b1;
                            empty_next = empty_next + 1'b1;
                        end
                        else if ((since_inc & mask) == '0)
                        begin
                            irq_bit     = 1'b1;
                            period_next = period_next + 1'b1;
                        end
                        else if (fill_sum >= SUM_W'(RING_SIZE))
                        begin
                            irq_bit = 1'b1;
                        end
                        since_next = irq_bit ? '0 : since_inc;
                        if (irq_bit)
                        begin
                            irq_next = irq_next + 1'b1;
                        end
                        inf_next  = inf_c + 1'b1;
                        pkt_next  = pkt_next + 1'b1;
                        head_next = (head_c == IDX_W'(RING_SIZE - 1)) ? '0 : head_c + 1'b1;
                    end
                    else
                    begin
                        inf_next   = inf_c + 1'b1;
                        pkt_next   = pkt_next + 1'b1;
                        since_next = since_inc;
                    end
                end
                tic_pkg::OP_RECLAIM:
                begin
                    slot_next = tail_c;
                    if (inf_c == '0 || !cur.tail_complete)
                    begin
                        status_next = tic_pkg::ST_EMPTY;
                    end
                    else if (state_reg == S_IDLE)
                    begin
                        // fetch the stored address first
                        ram_re  = 1'b1;
                        to_wait = 1'b1;
                    end
                    else
                    begin
                        freed_next = ram_rdata;
                        need_next  = (ram_rdata != '0);
                        ram_we     = 1'b1;
                        tail_next  = (tail_c == IDX_W'(RING_SIZE - 1)) ? '0 : tail_c + 1'b1;
                        inf_next   = inf_c - 1'b1;
                    end
                end
                tic_pkg::OP_CLEAR:
                begin
                    pkt_next    = '0;
                    irq_next    = '0;
                    empty_next  = '0;
                    period_next = '0;
                end
                tic_pkg::OP_INIT:
                begin
                    since_next  = '0;
                    inf_next    = '0;
                    head_next   = '0;
                    tail_next   = '0;
                    pkt_next    = '0;
                    irq_next    = '0;
                    empty_next  = '0;
                    period_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign emit = go && !to_wait;
    assign upd  = emit && cur.nic_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            result_valid <= 1'b0;
            for (int i = 0; i < NIC_COUNT; i++)
            begin
                since_reg[i]  <= '0;
                inf_reg[i]    <= '0;
                head_reg[i]   <= '0;
                tail_reg[i]   <= '0;
                pkt_reg[i]    <= '0;
                irq_reg[i]    <= '0;
                empty_reg[i]  <= '0;
                period_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:  state_reg <= to_wait ? S_WAIT : S_IDLE;
                S_WAIT:  state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
            result_valid <= emit;
            if (upd)
            begin
                since_reg[nic_idx]  <= since_next;
                inf_reg[nic_idx]    <= inf_next;
                head_reg[nic_idx]   <= head_next;
                tail_reg[nic_idx]   <= tail_next;
                pkt_reg[nic_idx]    <= pkt_next;
                irq_reg[nic_idx]    <= irq_next;
                empty_reg[nic_idx]  <= empty_next;
                period_reg[nic_idx] <= period_next;
            end
        end
    end

    // payload; an out-of-range controller gives all zeros
    always_ff @(posedge clk)
    begin
        if (to_wait)
        begin
            held_reg <= cur;
        end
        if (emit)
        begin
            status           <= status_next;
            slot             <= tic_pkg::SLOT_W'(slot_next);
            irq_request      <= irq_bit;
            length_out       <= len_next;
            freed_addr       <= freed_next;
            free_needed      <= need_next;
            inflight_out     <= cur.nic_ok ? tic_pkg::INF_OUT_W'(inf_next) : '0;
            packets_total    <= cur.nic_ok ? pkt_next : '0;
            interrupts_total <= cur.nic_ok ? irq_next : '0;
            empty_irqs       <= cur.nic_ok ? empty_next : '0;
            periodic_irqs    <= cur.nic_ok ? period_next : '0;
        end
    end

endmodule
